// ===== design/slot_reservation_scheduler_top_defines.svh =====
// Assertion macros used by the scheduler top module.
`ifndef SLOT_RESERVATION_SCHEDULER_TOP_DEFINES_SVH
`define SLOT_RESERVATION_SCHEDULER_TOP_DEFINES_SVH

// Checks that an antecedent implies a consequent on the same clock edge.
`define SRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an antecedent implies a consequent on the following clock edge.
`define SRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg
// Types and constants shared by the slot reservation scheduler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package srs_pkg;

    localparam int NUM_SLOTS_DEF = 256;
    localparam int NUM_TYPES_DEF = 4;
    localparam int CAP_W         = 8;
    localparam int TIME_W        = 8;
    localparam int LEN_W         = 9;
    localparam int END_W         = 9;
    localparam logic [END_W-1:0] END_MAX = 9'd511;

    localparam logic CMD_CLEAR   = 1'b0;
    localparam logic CMD_RESERVE = 1'b1;

    typedef struct packed {
        logic              command;
        logic [1:0]        bench_type;
        logic [TIME_W-1:0] earliest_time;
        logic [LEN_W-1:0]  length;
    } srs_in_t;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [END_W-1:0]  makespan;
        logic              no_fit;
    } srs_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_RESULT
    } srs_state_t;

    // Operation a cell applies while the ring rotates.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_DEC
    } srs_op_t;

    typedef struct packed {
        logic    shift;
        srs_op_t op;
    } srs_ctl_t;

endpackage

// ===== design/srs_cell.sv =====
// ----------------------------------------------------------------------------
// srs_cell
// One slot of a type's timeline ring: holds a capacity and hands it on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module srs_cell
    import srs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  srs_ctl_t         ctl,
    input  logic             sel,
    input  logic             dec_en,
    input  logic [CAP_W-1:0] load_value,
    input  logic [CAP_W-1:0] cap_in,
    output logic [CAP_W-1:0] cap_out
);

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;

    // The selected cell at the ring tail, which takes the head's value, is the one that is modified in a pass.
    always_comb
    begin
        cap_next = cap_reg;
        if (ctl.shift)
        begin
            cap_next = cap_in;
        end
        if (sel)
        begin
            unique case (ctl.op)
                OP_LOAD: cap_next = load_value;
                OP_DEC:  cap_next = dec_en ? cap_in - CAP_W'(1) : cap_in;
                default: cap_next = cap_next;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(1);
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    assign cap_out = cap_reg;

endmodule

// ===== design/srs_ring.sv =====
// ----------------------------------------------------------------------------
// srs_ring
// A ring of cells for one resource type, rotated one slot per cycle while ctl.shift is set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module srs_ring
    import srs_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  srs_ctl_t         ctl,
    input  logic             dec_en,
    input  logic [CAP_W-1:0] load_value,
    output logic [CAP_W-1:0] head_cap
);

    logic [CAP_W-1:0] cap [NUM_SLOTS];

    // Cell k takes cell k+1; cell NUM_SLOTS-1 takes the head and is written.
    for (genvar k = 0; k < NUM_SLOTS; k++)
    begin : g_cell
        srs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .sel        (k == NUM_SLOTS - 1),
            .dec_en     (dec_en),
            .load_value (load_value),
            .cap_in     (cap[(k + 1) % NUM_SLOTS]),
            .cap_out    (cap[k])
        );
    end

    assign head_cap = cap[0];

endmodule

// ===== design/slot_reservation_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// slot_reservation_scheduler_top
// First-fit reservation table over per-type slot timelines.
// ----------------------------------------------------------------------------
// Each resource type owns a ring of NUM_SLOTS capacity cells, and the rings
// that a transaction touches rotate by one slot per clock during its scan
// and apply passes. A reserve transaction first makes one full revolution
// of the selected ring that streams every slot past a run counter to find
// the first window of `length` nonzero slots at or after earliest_time. If
// a window is found, a second revolution decrements the slots of that window
// as they pass the head. If none is found, the second revolution is skipped
// and nothing changes. A clear transaction takes one revolution of every
// ring while the configured capacity in init_cap_reg is loaded. The result
// becomes valid after the second revolution for a reserve that fits, and
// after the first for a clear or a reserve that does not fit. One transaction
// is processed at a time. A result waits in an output register until taken,
// and the input stays stalled meanwhile and until the state has gone from
// ST_RESULT back to ST_IDLE after the result is taken.
// The capacity register may only be written while the block is idle.
`timescale 1ns / 1ps
module slot_reservation_scheduler_top
    import srs_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int NUM_TYPES = NUM_TYPES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  srs_in_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output srs_out_t         out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

`include "slot_reservation_scheduler_top_defines.svh"

    localparam int PW = $clog2(NUM_SLOTS + 1);
    localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int RW = PW + 1;

    srs_state_t state_reg, state_next;
    logic [CAP_W-1:0] init_cap_reg;
    srs_in_t          req_reg;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [RW-1:0]    run_reg, run_next;
    logic             found_reg, found_next;
    logic [PW-1:0]    start_reg, start_next;
    logic [END_W-1:0] end_reg;
    logic             out_valid_reg;
    srs_out_t         out_reg;

    logic [CAP_W-1:0] head [NUM_TYPES];
    logic [CAP_W-1:0] sel_head;
    logic             type_ok;
    logic [TW-1:0]    type_idx;
    logic             last_pos;
    logic             accept;
    logic             in_window;
    logic [PW:0]      end_full;

    assign type_ok  = (32'(req_reg.bench_type) < NUM_TYPES);
    assign type_idx = TW'(req_reg.bench_type);
    assign sel_head = type_ok ? head[type_idx] : '0;
    assign last_pos = (32'(pos_reg) == NUM_SLOTS - 1);
    assign accept   = in_valid && !in_stall;
    assign end_full = (PW + 1)'(start_reg) + (PW + 1)'(req_reg.length);
    assign in_window = found_reg && (pos_reg >= start_reg)
                       && ((PW + 1)'(pos_reg) < end_full);

    // Rings: pos_reg counts which slot sits at the head.
    for (genvar t = 0; t < NUM_TYPES; t++)
    begin : g_ring
        srs_ctl_t ctl;
        always_comb
        begin
            ctl.shift = (state_reg == ST_SCAN) || (state_reg == ST_APPLY);
            ctl.op    = OP_HOLD;
            if (state_reg == ST_SCAN && req_reg.command == CMD_CLEAR)
            begin
                ctl.op = OP_LOAD;
            end
            else if (state_reg == ST_APPLY && 32'(type_idx) == t && type_ok)
            begin
                ctl.op = OP_DEC;
            end
            if (!(req_reg.command == CMD_CLEAR || (type_ok && 32'(type_idx) == t)))
            begin
                ctl.shift = 1'b0;
            end
        end
        srs_ring #(.NUM_SLOTS(NUM_SLOTS)) u_ring (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .dec_en     (in_window),
            .load_value (init_cap_reg),
            .head_cap   (head[t])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_SCAN;
            ST_SCAN:   if (last_pos)
                       begin
                           state_next = (req_reg.command == CMD_RESERVE && found_next)
                                        ? ST_APPLY : ST_RESULT;
                       end
            ST_APPLY:  if (last_pos) state_next = ST_RESULT;
            ST_RESULT: if (!out_valid_reg) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Scan datapath.
    always_comb
    begin
        pos_next   = pos_reg;
        run_next   = run_reg;
        found_next = found_reg;
        start_next = start_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                pos_next   = '0;
                run_next   = '0;
                found_next = 1'b0;
                start_next = '0;
            end
            ST_SCAN, ST_APPLY:
            begin
                pos_next = last_pos ? '0 : pos_reg + PW'(1);
                if (state_reg == ST_SCAN && !found_reg && type_ok
                    && req_reg.length != '0
                    && 32'(pos_reg) >= 32'(req_reg.earliest_time))
                begin
                    if (sel_head != '0)
                    begin
                        run_next = run_reg + RW'(1);
                        if (32'(run_reg) + 1 == 32'(req_reg.length))
                        begin
                            found_next = 1'b1;
                            start_next = PW'(32'(pos_reg) + 1 - 32'(req_reg.length));
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            init_cap_reg  <= CAP_W'(1);
            end_reg       <= '0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            run_reg       <= '0;
            found_reg     <= 1'b0;
            start_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            run_reg   <= run_next;
            found_reg <= found_next;
            start_reg <= start_next;
            if (cfg_valid && cfg_ready)
            begin
                init_cap_reg <= cfg_data;
            end
            // A result is only loaded after the previous one has been taken.
            if (state_next == ST_RESULT && state_reg != ST_RESULT)
            begin
                out_valid_reg <= 1'b1;
                if (req_reg.command == CMD_CLEAR)
                begin
                    end_reg <= '0;
                end
                else if (found_next && 32'(end_full) > 32'(end_reg))
                begin
                    end_reg <= (32'(end_full) > 32'(END_MAX)) ? END_MAX
                                                              : END_W'(end_full);
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_data;
        end
        if (state_next == ST_RESULT && state_reg != ST_RESULT)
        begin
            if (req_reg.command == CMD_CLEAR)
            begin
                out_reg <= '{start_time: '0, makespan: '0, no_fit: 1'b0};
            end
            else
            begin
                out_reg.start_time <= found_next ? TIME_W'(start_next) : '0;
                out_reg.no_fit     <= !found_next;
                out_reg.makespan   <= (found_next && 32'(end_full) > 32'(end_reg))
                    ? ((32'(end_full) > 32'(END_MAX)) ? END_MAX : END_W'(end_full))
                    : end_reg;
            end
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SRS_ASSERT_IMP(a_out_in_result, clk, rst_n, out_valid_reg,
        state_reg == ST_RESULT, "result shown outside result state")
    `SRS_ASSERT_NEXT(a_accept_scan, clk, rst_n, accept,
        state_reg == ST_SCAN, "accepted transaction did not start a scan")
    `SRS_ASSERT_IMP(a_apply_found, clk, rst_n, state_reg == ST_APPLY,
        found_reg, "apply pass without a window")

endmodule

// ===== test/slot_reservation_scheduler_top_tb.sv =====
// ----------------------------------------------------------------------------
// slot_reservation_scheduler_top_tb
// Self-checking bench for the first-fit slot reservation scheduler.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of every capacity timeline and of the
// makespan. It works out the expected result of each accepted transaction and
// compares every accepted result against the oldest one it predicted.
// A short directed sequence comes first. Random phases follow, each under its
// own initial capacity; pairs of phases share an idle pattern on both channels.
// One long receiver hold-off fills the block up so that it stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module slot_reservation_scheduler_top_tb;
    import srs_pkg::*;

    localparam int  CLK_HALF    = 6;
    localparam int  PHASE_ITEMS = 180;
    localparam int  HOLD_CYCLES = 1500;
    localparam int  DRAIN_WAIT  = 2 * NUM_SLOTS_DEF + 80;
    localparam longint CYCLE_LIMIT = 3000000;

    // Scoreboard: predicts the result of each accepted request and checks
    // the results coming out of the block in order.
    class reservation_board;
        bit [CAP_W-1:0] capacity [NUM_TYPES_DEF][NUM_SLOTS_DEF];
        bit [END_W-1:0] latest_end;
        bit [CAP_W-1:0] load_value;
        srs_out_t       awaited[$];
        int             errors;
        int             clears;
        int             fits;
        int             misses;

        function new();
            load_value = 8'd1;
            latest_end = '0;
            foreach (capacity[k, t]) capacity[k][t] = 8'd1;
        endfunction

        // Notes an accepted request transaction and queues its result.
        function void note_request(srs_in_t req);
            srs_out_t res;
            int       run;
            int       first;
            int       stop;
            bit       found;
            res   = '0;
            run   = 0;
            first = 0;
            found = 0;
            if (req.command == CMD_CLEAR)
            begin
                foreach (capacity[k, t]) capacity[k][t] = load_value;
                latest_end = '0;
                clears++;
                awaited = {awaited, res};
                return;
            end
            if (req.bench_type < NUM_TYPES_DEF && req.length != 0)
            begin
                for (int t = req.earliest_time; t < NUM_SLOTS_DEF; t++)
                begin
                    if (capacity[req.bench_type][t] != 0)
                    begin
                        run++;
                        if (run == req.length)
                        begin
                            first = t + 1 - req.length;
                            found = 1;
                            break;
                        end
                    end
                    else
                    begin
                        run = 0;
                    end
                end
            end
            if (found)
            begin
                stop = first + req.length;
                for (int t = first; t < stop; t++)
                    capacity[req.bench_type][t] = capacity[req.bench_type][t] - 8'd1;
                if (stop > END_MAX) stop = END_MAX;
                if (stop > latest_end) latest_end = stop[END_W-1:0];
                fits++;
            end
            else
            begin
                misses++;
            end
            res.start_time = found ? first[TIME_W-1:0] : '0;
            res.makespan   = latest_end;
            res.no_fit     = !found;
            awaited = {awaited, res};
        endfunction

        // Checks one accepted result transaction against the oldest prediction.
        function void check_result(srs_out_t got);
            srs_out_t want;
            if (awaited.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.start_time !== want.start_time)
            begin
                $error("start_time: expected %0d, got %0d", want.start_time, got.start_time);
                errors++;
            end
            if (got.makespan !== want.makespan)
            begin
                $error("makespan: expected %0d, got %0d", want.makespan, got.makespan);
                errors++;
            end
            if (got.no_fit !== want.no_fit)
            begin
                $error("no_fit: expected %0b, got %0b", want.no_fit, got.no_fit);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    srs_in_t          in_data;
    logic             out_valid;
    logic             out_stall = 1'b0;
    srs_out_t         out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    reservation_board board;
    int      send_idle_pct;
    int      recv_idle_pct;
    bit      hold_request;
    bit      hold_started = 1'b0;
    int      hold_left = 0;
    longint  cycle_count = 0;

    slot_reservation_scheduler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // The run is cut off and failed once cycle_count passes CYCLE_LIMIT, as when the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver side: random stall, plus a long hold-off when one is requested.
    // The hold-off is counted here so the sender keeps offering meanwhile.
    always @(posedge clk)
    begin
        if (hold_request && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
        end
        out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Output monitor. Values read right after the edge are the ones that
    // were present at the edge, so the handshake is sampled without a race.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);
    end

    // Offers one request transaction, with random idle cycles ahead of it,
    // and returns once the block has accepted it.
    task automatic send_request(input srs_in_t req);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_request(req);
    endtask

    task automatic send_fields(input logic cmd, input int kind, input int from,
                               input int span);
        srs_in_t req;
        req.command       = cmd;
        req.bench_type    = kind[1:0];
        req.earliest_time = from[TIME_W-1:0];
        req.length        = span[LEN_W-1:0];
        send_request(req);
    endtask

    // Waits until every expected result has come back; the block is then idle
    // because each request produces exactly one result.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.load_value = value;
        cfg_valid <= 1'b0;
    endtask

    // Random request: mostly short windows near the start of the timeline so
    // that reservations pile up, with clears, overlong and zero lengths mixed in.
    function automatic srs_in_t random_request();
        srs_in_t req;
        int      pick;
        req.command       = ($urandom_range(0, 99) < 4) ? CMD_CLEAR : CMD_RESERVE;
        req.bench_type    = 2'($urandom_range(0, 3));
        req.earliest_time = ($urandom_range(0, 9) < 7) ? TIME_W'($urandom_range(0, 63))
                                                        : TIME_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 80)      req.length = LEN_W'($urandom_range(1, 16));
        else if (pick < 90) req.length = LEN_W'($urandom_range(17, 256));
        else if (pick < 95) req.length = '0;
        else                req.length = LEN_W'($urandom_range(257, 511));
        return req;
    endfunction

    initial
    begin
        logic [CAP_W-1:0] phase_caps [6];
        phase_caps = '{8'd255, 8'd0, 8'd1, 8'd2, 8'd128, 8'd7};
        board         = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        hold_request  = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 51;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset capacity of one per slot.
        send_fields(CMD_RESERVE, 0, 0, 1);      // first slot of an untouched timeline
        send_fields(CMD_RESERVE, 0, 0, 1);      // that slot is used up, so the next one
        send_fields(CMD_RESERVE, 1, 0, 256);    // the whole timeline in one window
        send_fields(CMD_RESERVE, 1, 0, 1);      // nothing left on that type
        send_fields(CMD_RESERVE, 2, 10, 0);     // zero length never fits
        send_fields(CMD_RESERVE, 2, 255, 1);    // last slot alone
        send_fields(CMD_RESERVE, 2, 255, 2);    // window runs past the end
        send_fields(CMD_RESERVE, 3, 0, 511);    // longest encodable length
        send_fields(CMD_RESERVE, 3, 128, 128);  // exactly the tail of the timeline
        send_fields(CMD_RESERVE, 3, 100, 30);   // window cannot fit before the used tail
        send_fields(CMD_RESERVE, 3, 127, 2);    // blocked by the used tail
        send_fields(CMD_CLEAR, 3, 255, 511);    // clear ignores the other fields
        send_fields(CMD_RESERVE, 3, 0, 256);
        send_fields(CMD_RESERVE, 0, 170, 85);
        send_fields(CMD_RESERVE, 1, 85, 170);
        send_fields(CMD_CLEAR, 0, 0, 0);
        wait_drained();

        // Random phases: capacity changes only while the block is idle, and a
        // clear opens each phase so that the new capacity is loaded.
        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 13;
                recv_idle_pct = 51;
            end
            else if (p < 4)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 13;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(phase_caps[p]);
            send_fields(CMD_CLEAR, 0, 0, 1);
            if (p == 4) hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request());
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        board.errors += board.awaited.size();
        $display("Covered %0d clears, %0d fitted and %0d refused reservations",
                 board.clears, board.fits, board.misses);
        $display("over six capacity settings including zero and 255, with one long output hold.");
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/srs_pkg.sv
design/srs_cell.sv
design/srs_ring.sv
design/slot_reservation_scheduler_top.sv
test/slot_reservation_scheduler_top_tb.sv
